// ===== rtl/core/slbm_pkg.sv =====
// Shared types and constants for the serial loaded bank mapper.
// No dependencies; imported by every module under rtl/core.
package slbm_pkg;

  // Default index widths of the translated memory addresses
  localparam int PRG_INDEX_BITS_DEF = 19;
  localparam int CHR_INDEX_BITS_DEF = 17;

  // Reset values of the mapper state
  localparam logic [4:0] SHIFT_INIT   = 5'h10;
  localparam logic [4:0] CONTROL_INIT = 5'h0C;
  localparam logic [4:0] CONTROL_PRG_FORCE = 5'h0C;
  localparam logic [1:0] MIRROR_INIT  = 2'd3;
  localparam logic [2:0] LOAD_COUNT   = 3'd5;

  // Size register reset values and lower saturation limits (log2 bytes)
  localparam logic [4:0] PRG_LOG2_INIT = 5'd15;
  localparam logic [4:0] CHR_LOG2_INIT = 5'd13;
  localparam logic [4:0] PRG_LOG2_MIN  = 5'd14;
  localparam logic [4:0] CHR_LOG2_MIN  = 5'd13;

  // Bus access kinds
  typedef enum logic [1:0] {
    MODE_CPU_WR = 2'd0,
    MODE_CPU_RD = 2'd1,
    MODE_PPU_RD = 2'd2,
    MODE_PPU_WR = 2'd3
  } access_mode_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PRG_SIZE = 1'b0,
    CFG_CHR_SIZE = 1'b1
  } cfg_reg_t;

  // Target of a completed serial load, from address bits 14:13
  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG      = 2'd3
  } bank_sel_t;

  // Program bank modes from control bits 3:2 (other codes: 32K switching)
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // Bank state seen by the address translator
  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [4:0] prg_bank;
    logic [4:0] prg_log2;
    logic [4:0] chr_log2;
  } bank_state_t;

endpackage

// ===== rtl/core/slbm_regs.sv =====
// Serial loader, bank registers and size configuration registers.
// Depends on slbm_pkg.
module slbm_regs #(
  parameter int PRG_INDEX_BITS = slbm_pkg::PRG_INDEX_BITS_DEF,
  parameter int CHR_INDEX_BITS = slbm_pkg::CHR_INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [4:0]                cfg_data,
  input  logic                      step,
  input  slbm_pkg::access_mode_t    mode,
  input  logic [15:0]               addr,
  input  logic [7:0]                data,
  output slbm_pkg::bank_state_t     state,
  output logic [1:0]                mirror_next
);
  import slbm_pkg::*;

  logic [4:0] prg_size_log2;
  logic [4:0] chr_size_log2;
  logic [4:0] shifter, shifter_next;
  logic [2:0] bit_count, bit_count_next;
  logic [4:0] control, control_next;
  logic [4:0] chr_bank_low, chr_bank_low_next;
  logic [4:0] chr_bank_high, chr_bank_high_next;
  logic [4:0] prg_bank, prg_bank_next;
  logic [1:0] mirroring;

  logic [4:0] shift_in;
  logic [2:0] count_inc;
  logic       cpu_wr;
  bank_sel_t  sel;

  // Shift the serial bit and decide what a CPU write loads
  always_comb begin
    cpu_wr             = step && (mode == MODE_CPU_WR);
    shift_in           = {data[0], shifter[4:1]};
    count_inc          = bit_count + 3'd1;
    sel                = bank_sel_t'(addr[14:13]);
    shifter_next       = shifter;
    bit_count_next     = bit_count;
    control_next       = control;
    chr_bank_low_next  = chr_bank_low;
    chr_bank_high_next = chr_bank_high;
    prg_bank_next      = prg_bank;
    mirror_next        = mirroring;
    if (cpu_wr) begin
      if (data[7]) begin
        shifter_next   = SHIFT_INIT;
        bit_count_next = '0;
        control_next   = control | CONTROL_PRG_FORCE;
      end else if (count_inc == LOAD_COUNT) begin
        if (addr[15]) begin
          case (sel)
            SEL_CONTROL:  control_next       = shift_in;
            SEL_CHR_LOW:  chr_bank_low_next  = shift_in;
            SEL_CHR_HIGH: chr_bank_high_next = shift_in;
            SEL_PRG:      prg_bank_next      = shift_in;
            default:      prg_bank_next      = shift_in;
          endcase
        end
        shifter_next   = SHIFT_INIT;
        bit_count_next = '0;
        mirror_next    = control_next[1:0];
      end else begin
        shifter_next   = shift_in;
        bit_count_next = count_inc;
      end
    end
  end

  // Hold mapper state; advance on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      shifter       <= SHIFT_INIT;
      bit_count     <= '0;
      control       <= CONTROL_INIT;
      chr_bank_low  <= '0;
      chr_bank_high <= '0;
      prg_bank      <= '0;
      mirroring     <= MIRROR_INIT;
    end else begin
      shifter       <= shifter_next;
      bit_count     <= bit_count_next;
      control       <= control_next;
      chr_bank_low  <= chr_bank_low_next;
      chr_bank_high <= chr_bank_high_next;
      prg_bank      <= prg_bank_next;
      mirroring     <= mirror_next;
    end
  end

  // Size configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_size_log2 <= PRG_LOG2_INIT;
      chr_size_log2 <= CHR_LOG2_INIT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PRG_SIZE: prg_size_log2 <= cfg_data;
        CFG_CHR_SIZE: chr_size_log2 <= cfg_data;
        default:      chr_size_log2 <= cfg_data;
      endcase
    end
  end

  // Saturate sizes into the supported range and publish the state
  always_comb begin
    state.control       = control;
    state.chr_bank_low  = chr_bank_low;
    state.chr_bank_high = chr_bank_high;
    state.prg_bank      = prg_bank;
    if (prg_size_log2 < PRG_LOG2_MIN)
      state.prg_log2 = PRG_LOG2_MIN;
    else if (prg_size_log2 > 5'(PRG_INDEX_BITS))
      state.prg_log2 = 5'(PRG_INDEX_BITS);
    else
      state.prg_log2 = prg_size_log2;
    if (chr_size_log2 < CHR_LOG2_MIN)
      state.chr_log2 = CHR_LOG2_MIN;
    else if (chr_size_log2 > 5'(CHR_INDEX_BITS))
      state.chr_log2 = 5'(CHR_INDEX_BITS);
    else
      state.chr_log2 = chr_size_log2;
  end

`ifndef SYNTH
  // The serial count empties on the fifth bit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 3'd4)
    else $error("serial bit count out of range");

  // A reset write empties the shifter and forces the program mode bits
  a_reset_write: assert property (@(posedge clk) disable iff (rst)
    (cpu_wr && data[7]) |=>
      (shifter == SHIFT_INIT && bit_count == 3'd0 && control[3:2] == 2'b11))
    else $error("reset write did not clear the serial loader");

  // Mirroring moves only when a fifth bit is shifted in
  a_mirror_hold: assert property (@(posedge clk) disable iff (rst)
    !(cpu_wr && !data[7] && count_inc == LOAD_COUNT) |=> $stable(mirroring))
    else $error("mirroring changed without a completed load");
`endif

endmodule

// ===== rtl/core/slbm_xlate.sv =====
// Address translation from bus address to program ROM / character memory index.
// Depends on slbm_pkg; purely combinational.
module slbm_xlate #(
  parameter int PRG_INDEX_BITS = slbm_pkg::PRG_INDEX_BITS_DEF,
  parameter int CHR_INDEX_BITS = slbm_pkg::CHR_INDEX_BITS_DEF
) (
  input  slbm_pkg::access_mode_t     mode,
  input  logic [15:0]                addr,
  input  slbm_pkg::bank_state_t      state,
  output logic [PRG_INDEX_BITS-1:0]  prg_index,
  output logic [CHR_INDEX_BITS-1:0]  chr_index,
  output logic                       index_valid
);
  import slbm_pkg::*;

  localparam int PW = PRG_INDEX_BITS;
  localparam int CW = CHR_INDEX_BITS;

  logic [PW:0]   prg_span;
  logic [PW-1:0] prg_mask;
  logic [PW-1:0] prg_last;
  logic [PW-1:0] prg_raw;
  logic [CW:0]   chr_span;
  logic [CW-1:0] chr_mask;
  logic [CW-1:0] chr_raw;
  logic          upper;

  // Wrap masks from the saturated memory sizes
  always_comb begin
    prg_span = (PW + 1)'(1) << state.prg_log2;
    prg_mask = PW'(prg_span - (PW + 1)'(1));
    prg_last = PW'(prg_span - (PW + 1)'(16384));
    chr_span = (CW + 1)'(1) << state.chr_log2;
    chr_mask = CW'(chr_span - (CW + 1)'(1));
  end

  // Program ROM bank layout selected by control bits 3:2
  always_comb begin
    upper = addr[14];
    case (state.control[3:2])
      PRG_MODE_FIX_FIRST: begin
        if (upper) prg_raw = PW'({state.prg_bank, addr[13:0]});
        else       prg_raw = PW'(addr[14:0]);
      end
      PRG_MODE_FIX_LAST: begin
        if (upper) prg_raw = prg_last + PW'(addr[13:0]);
        else       prg_raw = PW'({state.prg_bank, addr[13:0]});
      end
      default: prg_raw = PW'({state.prg_bank[4:1], addr[14:0]});
    endcase
  end

  // Character memory layout selected by control bit 4
  always_comb begin
    if (!state.control[4])
      chr_raw = CW'({state.chr_bank_low[4:1], addr[12:0]});
    else if (!addr[12])
      chr_raw = CW'({state.chr_bank_low, addr[11:0]});
    else
      chr_raw = CW'({state.chr_bank_high, addr[11:0]});
  end

  // Drive the index for the kind of access
  always_comb begin
    prg_index   = '0;
    chr_index   = '0;
    index_valid = 1'b0;
    case (mode)
      MODE_CPU_WR: index_valid = 1'b0;
      MODE_CPU_RD: begin
        if (addr[15]) begin
          prg_index   = prg_raw & prg_mask;
          index_valid = 1'b1;
        end
      end
      MODE_PPU_RD, MODE_PPU_WR: begin
        chr_index   = chr_raw & chr_mask;
        index_valid = 1'b1;
      end
      default: index_valid = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/serial_loaded_bank_mapper_core.sv =====
// Serial loaded bank mapper: top level with input stage and result register.
// Depends on slbm_pkg, slbm_regs and slbm_xlate.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one bus access per transaction:
//   mode, addr and data. Output channel (out_valid / out_stall) returns one
//   result per access: prg_index, chr_index, index_valid and mirror_mode.
//   The configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data)
//   sets the program and character memory sizes; cfg_ready is always high.
// Timing:
//   An accepted access is registered in the input register, then translated and
//   written into the result register, which raises out_valid. One access is
//   accepted every cycle while out_stall does not hold a result; the rate is set
//   by the single input register feeding the result register.
// Reset (rst, synchronous): empties both stages and restores the power-on
//   bank state and memory sizes.
// Stall: while out_stall holds a result, the next access waits in the input
//   register and in_stall rises only once that register is also occupied.
module serial_loaded_bank_mapper_core #(
  parameter int PRG_INDEX_BITS = slbm_pkg::PRG_INDEX_BITS_DEF,
  parameter int CHR_INDEX_BITS = slbm_pkg::CHR_INDEX_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic [15:0]               addr,
  input  logic [7:0]                data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PRG_INDEX_BITS-1:0] prg_index,
  output logic [CHR_INDEX_BITS-1:0] chr_index,
  output logic                      index_valid,
  output logic [1:0]                mirror_mode,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [0:0]                cfg_index,
  input  logic [4:0]                cfg_data
);
  import slbm_pkg::*;

  logic        s_valid;
  logic [1:0]  s_mode;
  logic [15:0] s_addr;
  logic [7:0]  s_data;
  logic        advance;
  logic        step;
  logic        in_take;

  access_mode_t              s_kind;
  bank_state_t               state;
  logic [1:0]                mirror_next;
  logic [PRG_INDEX_BITS-1:0] prg_index_next;
  logic [CHR_INDEX_BITS-1:0] chr_index_next;
  logic                      index_valid_next;

  // Handshake: the result register frees the input stage when it can move
  assign advance   = !out_valid || !out_stall;
  assign step      = s_valid && advance;
  assign in_stall  = s_valid && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign s_kind    = access_mode_t'(s_mode);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_take) begin
      s_valid <= 1'b1;
    end else if (step) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s_mode <= mode;
      s_addr <= addr;
      s_data <= data;
    end
  end

  slbm_regs #(
    .PRG_INDEX_BITS (PRG_INDEX_BITS),
    .CHR_INDEX_BITS (CHR_INDEX_BITS)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (step),
    .mode        (s_kind),
    .addr        (s_addr),
    .data        (s_data),
    .state       (state),
    .mirror_next (mirror_next)
  );

  slbm_xlate #(
    .PRG_INDEX_BITS (PRG_INDEX_BITS),
    .CHR_INDEX_BITS (CHR_INDEX_BITS)
  ) u_xlate (
    .mode        (s_kind),
    .addr        (s_addr),
    .state       (state),
    .prg_index   (prg_index_next),
    .chr_index   (chr_index_next),
    .index_valid (index_valid_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prg_index   <= prg_index_next;
      chr_index   <= chr_index_next;
      index_valid <= index_valid_next;
      mirror_mode <= mirror_next;
    end
  end

`ifndef SYNTH
  // Hold a waiting access in the input stage while the result is stalled
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s_valid && out_valid && out_stall) |=> s_valid)
    else $error("input stage lost a transaction under stall");

  // An unmapped result carries zero indexes
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !index_valid) |-> (prg_index == '0 && chr_index == '0))
    else $error("unmapped access produced a nonzero index");

  // A mapped result targets exactly one memory
  a_one_target: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_valid) |-> (prg_index == '0 || chr_index == '0))
    else $error("result maps into both memories");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for serial_loaded_bank_mapper_core: directed table, then random phases.
// Depends on slbm_pkg and the RTL under rtl/core; predicts every transaction in-line.
`timescale 1ns / 100ps

module testbench;
  import slbm_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct packed {
    logic [PRG_INDEX_BITS_DEF-1:0] prg_index;
    logic [CHR_INDEX_BITS_DEF-1:0] chr_index;
    logic                          index_valid;
    logic [1:0]                    mirror_mode;
  } map_result_t;

  typedef struct packed {
    access_mode_t mode;
    logic [15:0]  addr;
    logic [7:0]   data;
    logic         fixed;
    map_result_t  want;
  } access_row_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    mode;
  logic [15:0]                   addr;
  logic [7:0]                    data;
  logic                          out_valid;
  logic                          out_stall;
  logic [PRG_INDEX_BITS_DEF-1:0] prg_index;
  logic [CHR_INDEX_BITS_DEF-1:0] chr_index;
  logic                          index_valid;
  logic [1:0]                    mirror_mode;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [0:0]                    cfg_index;
  logic [4:0]                    cfg_data;

  // Predicted mapper state and memory sizes
  logic [4:0] shift_reg;
  logic [2:0] shift_cnt;
  logic [4:0] ctrl_reg;
  logic [4:0] chr_lo_bank;
  logic [4:0] chr_hi_bank;
  logic [4:0] prg_bank_reg;
  logic [1:0] mirror_reg;
  logic [4:0] prg_lg;
  logic [4:0] chr_lg;

  map_result_t pending_results[$];
  access_row_t access_rows[DIR_ROWS];
  int          errors;
  int          send_idle_pct;
  int          stall_pct;
  int          cycles;

  serial_loaded_bank_mapper_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .addr        (addr),
    .data        (data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prg_index   (prg_index),
    .chr_index   (chr_index),
    .index_valid (index_valid),
    .mirror_mode (mirror_mode),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Advance the mapper state by one bus access and work out its result
  task automatic map_access(input access_mode_t m, input logic [15:0] a,
                            input logic [7:0] d, output map_result_t r);
    int unsigned lg;
    int unsigned size;
    int unsigned idx;
    int unsigned ca;
    r = '0;
    case (m)
      MODE_CPU_WR: begin
        if (d[7]) begin
          ctrl_reg  = ctrl_reg | CONTROL_PRG_FORCE;
          shift_reg = SHIFT_INIT;
          shift_cnt = '0;
        end else begin
          shift_reg = {d[0], shift_reg[4:1]};
          shift_cnt = shift_cnt + 3'd1;
          if (shift_cnt == LOAD_COUNT) begin
            // Fifth bit: load the selected register, if in cartridge space
            if (a[15]) begin
              case (bank_sel_t'(a[14:13]))
                SEL_CONTROL:  ctrl_reg     = shift_reg;
                SEL_CHR_LOW:  chr_lo_bank  = shift_reg;
                SEL_CHR_HIGH: chr_hi_bank  = shift_reg;
                default:      prg_bank_reg = shift_reg;
              endcase
            end
            shift_reg  = SHIFT_INIT;
            shift_cnt  = '0;
            mirror_reg = ctrl_reg[1:0];
          end
        end
      end
      MODE_CPU_RD: begin
        if (a[15]) begin
          lg = (prg_lg < PRG_LOG2_MIN) ? 32'(PRG_LOG2_MIN) :
               (prg_lg > PRG_INDEX_BITS_DEF) ? 32'(PRG_INDEX_BITS_DEF) : 32'(prg_lg);
          size = 32'd1 << lg;
          case (ctrl_reg[3:2])
            PRG_MODE_FIX_FIRST: begin
              idx = a[14] ? prg_bank_reg * 32'h4000 + (a - 32'hC000) : a - 32'h8000;
            end
            PRG_MODE_FIX_LAST: begin
              idx = a[14] ? (size - 32'h4000) + (a - 32'hC000)
                          : prg_bank_reg * 32'h4000 + (a - 32'h8000);
            end
            default: begin
              idx = (prg_bank_reg & 5'h1E) * 32'h4000 + (a - 32'h8000);
            end
          endcase
          r.prg_index   = PRG_INDEX_BITS_DEF'(idx & (size - 32'd1));
          r.index_valid = 1'b1;
        end
      end
      default: begin
        lg = (chr_lg < CHR_LOG2_MIN) ? 32'(CHR_LOG2_MIN) :
             (chr_lg > CHR_INDEX_BITS_DEF) ? 32'(CHR_INDEX_BITS_DEF) : 32'(chr_lg);
        ca = 32'(a[12:0]);
        if (!ctrl_reg[4])
          idx = (chr_lo_bank & 5'h1E) * 32'h1000 + ca;
        else if (ca < 32'h1000)
          idx = chr_lo_bank * 32'h1000 + ca;
        else
          idx = chr_hi_bank * 32'h1000 + (ca - 32'h1000);
        r.chr_index   = CHR_INDEX_BITS_DEF'(idx & ((32'd1 << lg) - 32'd1));
        r.index_valid = 1'b1;
      end
    endcase
    r.mirror_mode = mirror_reg;
  endtask

  // Offer one access, hold it until accepted, then queue its expected result
  task automatic issue(input access_mode_t m, input logic [15:0] a, input logic [7:0] d,
                       input logic fixed, input map_result_t fixed_res);
    map_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    addr     <= a;
    data     <= d;
    do @(posedge clk); while (in_stall);
    map_access(m, a, d, pred);
    pending_results.push_back(fixed ? fixed_res : pred);
  endtask

  // Stop sending and wait until every queued result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write one size register
  task automatic write_size(input cfg_reg_t idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PRG_SIZE) prg_lg = val;
    else chr_lg = val;
  endtask

  // Reconfigure both memory sizes while the block is idle
  task automatic set_sizes(input logic [4:0] prg_val, input logic [4:0] chr_val);
    drain();
    repeat (4) @(posedge clk);
    write_size(CFG_PRG_SIZE, prg_val);
    write_size(CFG_CHR_SIZE, chr_val);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly complete serial loads and reads, some noise
  task automatic run_phase(input int n_items, input int idle_pct, input int stall_in,
                           input int hold_at);
    int          cnt;
    int          pick;
    logic [15:0] base;
    logic [15:0] a;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in;
    cnt           = 0;
    while (cnt < n_items) begin
      if (hold_at >= 0 && cnt >= hold_at) begin
        hold_at = -1;
        drain();
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
        if ($urandom_range(3) == 0) begin
          issue(MODE_CPU_WR, 16'($urandom), 8'h80 | 8'($urandom_range(255)), 1'b0, '0);
          cnt++;
        end
        base = ($urandom_range(9) == 0) ? 16'h0000 : 16'h8000;
        repeat (5) begin
          issue(MODE_CPU_WR, base | 16'($urandom_range(16'h7FFF)),
                8'($urandom_range(127)), 1'b0, '0);
          cnt++;
        end
      end else if (pick < 90) begin
        case ($urandom_range(2))
          0: begin
            a = ($urandom_range(4) == 0) ? 16'($urandom)
                                         : (16'h8000 | 16'($urandom_range(16'h7FFF)));
            issue(MODE_CPU_RD, a, 8'($urandom), 1'b0, '0);
          end
          1: issue(MODE_PPU_RD, 16'($urandom), 8'($urandom), 1'b0, '0);
          default: issue(MODE_PPU_WR, 16'($urandom), 8'($urandom), 1'b0, '0);
        endcase
        cnt++;
      end else begin
        issue(access_mode_t'($urandom_range(3)), 16'($urandom), 8'($urandom), 1'b0, '0);
        cnt++;
      end
    end
  endtask

  task automatic report(input string fld, input int unsigned want, input int unsigned got);
    $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, fld, want, got);
    errors++;
  endtask

  // Drive the receiver stall and check each result transaction
  always @(posedge clk) begin : result_check
    map_result_t want;
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual 0x%0h 0x%0h %0d %0d", $time,
                 prg_index, chr_index, index_valid, mirror_mode);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (prg_index !== want.prg_index) report("prg_index", want.prg_index, prg_index);
        if (chr_index !== want.chr_index) report("chr_index", want.chr_index, chr_index);
        if (index_valid !== want.index_valid)
          report("index_valid", want.index_valid, index_valid);
        if (mirror_mode !== want.mirror_mode)
          report("mirror_mode", want.mirror_mode, mirror_mode);
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = MODE_CPU_WR;
    addr          = '0;
    data          = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_PRG_SIZE;
    cfg_data      = '0;
    errors        = 0;
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    shift_reg     = SHIFT_INIT;
    shift_cnt     = '0;
    ctrl_reg      = CONTROL_INIT;
    chr_lo_bank   = '0;
    chr_hi_bank   = '0;
    prg_bank_reg  = '0;
    mirror_reg    = MIRROR_INIT;
    prg_lg        = PRG_LOG2_INIT;
    chr_lg        = CHR_LOG2_INIT;

    // Directed accesses; fixed rows carry a hand-computed result
    access_rows = '{
      // power-on state: character index 0, last address of 8K
      '{MODE_PPU_RD, 16'h0000, 8'h00, 1'b1, '{19'h0, 17'h0, 1'b1, 2'd3}},
      '{MODE_PPU_WR, 16'hFFFF, 8'hFF, 1'b1, '{19'h0, 17'h1FFF, 1'b1, 2'd3}},
      // open bus below cartridge space
      '{MODE_CPU_RD, 16'h7FFF, 8'h00, 1'b1, '{19'h0, 17'h0, 1'b0, 2'd3}},
      // fixed-last mode at 32K: first and last bytes
      '{MODE_CPU_RD, 16'h8000, 8'h00, 1'b1, '{19'h0, 17'h0, 1'b1, 2'd3}},
      '{MODE_CPU_RD, 16'hFFFF, 8'h00, 1'b1, '{19'h7FFF, 17'h0, 1'b1, 2'd3}},
      // reset write, then a reset write in the middle of a load
      '{MODE_CPU_WR, 16'h8000, 8'h80, 1'b1, '{19'h0, 17'h0, 1'b0, 2'd3}},
      '{MODE_CPU_WR, 16'hE000, 8'h01, 1'b1, '{19'h0, 17'h0, 1'b0, 2'd3}},
      '{MODE_CPU_WR, 16'hE000, 8'hFF, 1'b1, '{19'h0, 17'h0, 1'b0, 2'd3}},
      // program bank load of all ones
      '{MODE_CPU_WR, 16'hE000, 8'h01, 1'b0, '0},
      '{MODE_CPU_WR, 16'hE000, 8'h7F, 1'b0, '0},
      '{MODE_CPU_WR, 16'hE000, 8'h41, 1'b0, '0},
      '{MODE_CPU_WR, 16'hE000, 8'h03, 1'b0, '0},
      '{MODE_CPU_WR, 16'hFFFF, 8'h01, 1'b0, '0},
      // control load: 4K character banks, fixed-first, vertical
      '{MODE_CPU_WR, 16'h9FFF, 8'h00, 1'b0, '0},
      '{MODE_CPU_WR, 16'h9FFF, 8'h01, 1'b0, '0},
      '{MODE_CPU_WR, 16'h9FFF, 8'h7E, 1'b0, '0},
      '{MODE_CPU_WR, 16'h9FFF, 8'h01, 1'b0, '0},
      '{MODE_CPU_WR, 16'h8000, 8'h01, 1'b0, '0},
      '{MODE_CPU_RD, 16'hC000, 8'h00, 1'b0, '0},
      '{MODE_PPU_RD, 16'h1000, 8'h00, 1'b0, '0},
      // full load below cartridge space: no register, mirroring recomputed
      '{MODE_CPU_WR, 16'h7FFF, 8'h01, 1'b0, '0},
      '{MODE_CPU_WR, 16'h7FFF, 8'h01, 1'b0, '0},
      '{MODE_CPU_WR, 16'h7FFF, 8'h00, 1'b0, '0},
      '{MODE_CPU_WR, 16'h0000, 8'h00, 1'b0, '0},
      '{MODE_CPU_WR, 16'h0000, 8'h00, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue(access_rows[i].mode, access_rows[i].addr, access_rows[i].data,
            access_rows[i].fixed, access_rows[i].want);
    end

    // Random phases over size extremes, saturation, idle patterns and receiver stalls
    set_sizes(5'd19, 5'd17);
    run_phase(350, 0, 0, -1);
    set_sizes(5'd14, 5'd13);
    run_phase(350, 84, 0, -1);
    set_sizes(5'd0, 5'd31);
    run_phase(350, 0, 84, 120);
    set_sizes(5'd31, 5'd0);
    run_phase(350, 26, 26, -1);
    set_sizes(5'($urandom_range(31)), 5'($urandom_range(31)));
    run_phase(350, 0, 0, -1);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
